// ===== rtl/core/aptf_pkg.sv =====
package aptf_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int COORD_W      = 32;
	localparam int ANGLE_W      = 16;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 4;
	localparam int TRIG_W       = FRAC_BITS + 2;
	localparam int DELTA_W      = COORD_W + 1;
	localparam int CORDIC_STEPS = 30;
	localparam int STEP_W       = 5;
	localparam int CORDIC_W     = 33;
	localparam int Z_W          = 32;
	localparam int ATAN_W       = 30;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POSITION_X     = 4'd0,
		REG_POSITION_Y     = 4'd1,
		REG_SCALE_FACTOR   = 4'd2,
		REG_OFFSET_X       = 4'd3,
		REG_OFFSET_Y       = 4'd4,
		REG_PIVOT_X        = 4'd5,
		REG_PIVOT_Y        = 4'd6,
		REG_ROTATION_ANGLE = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
		logic                      saturated;
	} result_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
	} delta_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] position_x;
		logic signed [COORD_W-1:0] position_y;
		logic signed [COORD_W-1:0] scale_factor;
		logic signed [COORD_W-1:0] offset_x;
		logic signed [COORD_W-1:0] offset_y;
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
		logic signed [TRIG_W-1:0]  cosine;
		logic signed [TRIG_W-1:0]  sine;
	} cfg_t;

	// arctangent of 2^-i as a fraction of a full turn, 2^32 units per turn
	function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] step);
		logic [ATAN_W-1:0] r;
		case (step)
			5'd0:    r = 30'd536870912;
			5'd1:    r = 30'd316933406;
			5'd2:    r = 30'd167458907;
			5'd3:    r = 30'd85004756;
			5'd4:    r = 30'd42667331;
			5'd5:    r = 30'd21354465;
			5'd6:    r = 30'd10679838;
			5'd7:    r = 30'd5340245;
			5'd8:    r = 30'd2670163;
			5'd9:    r = 30'd1335087;
			5'd10:   r = 30'd667544;
			5'd11:   r = 30'd333772;
			5'd12:   r = 30'd166886;
			5'd13:   r = 30'd83443;
			5'd14:   r = 30'd41722;
			5'd15:   r = 30'd20861;
			5'd16:   r = 30'd10430;
			5'd17:   r = 30'd5215;
			5'd18:   r = 30'd2608;
			5'd19:   r = 30'd1304;
			5'd20:   r = 30'd652;
			5'd21:   r = 30'd326;
			5'd22:   r = 30'd163;
			5'd23:   r = 30'd81;
			5'd24:   r = 30'd41;
			5'd25:   r = 30'd20;
			5'd26:   r = 30'd10;
			5'd27:   r = 30'd5;
			5'd28:   r = 30'd3;
			5'd29:   r = 30'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/aptf_fifo.sv =====
module aptf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic [AW:0]      rd_next;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_next = rd_ptr_q + (AW+1)'(rd_en);
	assign rd_data = rd_data_q;

	// head register: next oldest entry, or the incoming one when the queue runs dry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q[AW-1:0]] <= wr_data;
		end
		if (rd_next == wr_ptr_q) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_next[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + (AW+1)'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + (AW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/aptf_trig.sv =====
module aptf_trig (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [aptf_pkg::ANGLE_W-1:0]        angle,
	output logic                                busy,
	output logic signed [aptf_pkg::TRIG_W-1:0]  cosine,
	output logic signed [aptf_pkg::TRIG_W-1:0]  sine
);
	import aptf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROT  = 3'b010,
		ST_FIN  = 3'b100
	} trig_state_t;

	localparam logic signed [TRIG_W-1:0] ONE = TRIG_W'(1) << FRAC_BITS;

	trig_state_t                state_q;
	logic [STEP_W-1:0]          step_q;
	logic [1:0]                 quad_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [Z_W-1:0]      z_q;
	logic signed [TRIG_W-1:0]   cos_q;
	logic signed [TRIG_W-1:0]   sin_q;

	logic [31:0]                turn;
	logic [29:0]                residual;
	logic signed [CORDIC_W-1:0] xs;
	logic signed [CORDIC_W-1:0] ys;
	logic signed [Z_W-1:0]      atan;
	logic signed [TRIG_W-1:0]   c_rnd;
	logic signed [TRIG_W-1:0]   s_rnd;

	// round half up to FRAC_BITS and clamp to [-1, +1]
	function automatic logic signed [TRIG_W-1:0] unit_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] t;
		logic signed [CORDIC_W:0] r;
		logic signed [TRIG_W-1:0] o;
		t = (CORDIC_W+1)'(v) + ((CORDIC_W+1)'(1) <<< (29 - FRAC_BITS));
		r = t >>> (30 - FRAC_BITS);
		if (r > (CORDIC_W+1)'(ONE)) begin
			o = ONE;
		end else if (r < -(CORDIC_W+1)'(ONE)) begin
			o = -ONE;
		end else begin
			o = TRIG_W'(r);
		end
		return o;
	endfunction

	function automatic logic signed [TRIG_W-1:0] quad_cos(input logic [1:0] q,
			input logic signed [TRIG_W-1:0] c, input logic signed [TRIG_W-1:0] s);
		logic signed [TRIG_W-1:0] o;
		case (q)
			2'd0:    o = c;
			2'd1:    o = -s;
			2'd2:    o = -c;
			default: o = s;
		endcase
		return o;
	endfunction

	function automatic logic signed [TRIG_W-1:0] quad_sin(input logic [1:0] q,
			input logic signed [TRIG_W-1:0] c, input logic signed [TRIG_W-1:0] s);
		logic signed [TRIG_W-1:0] o;
		case (q)
			2'd0:    o = s;
			2'd1:    o = c;
			2'd2:    o = -s;
			default: o = -c;
		endcase
		return o;
	endfunction

	assign turn     = 32'(angle[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
	assign residual = turn[29:0];
	assign xs       = x_q >>> step_q;
	assign ys       = y_q >>> step_q;
	assign atan     = $signed(Z_W'(atan_turn(step_q)));
	assign c_rnd    = unit_round(x_q);
	assign s_rnd    = unit_round(y_q);

	assign busy   = (state_q != ST_IDLE);
	assign cosine = cos_q;
	assign sine   = sin_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					quad_q <= turn[31:30];
					x_q    <= CORDIC_GAIN;
					y_q    <= '0;
					z_q    <= $signed(Z_W'(residual));
				end
			end
			ST_ROT: begin
				if (!z_q[Z_W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cos_q   <= ONE;
			sin_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q <= '0;
						// exact quarter turn needs no rotation
						if (residual == '0) begin
							cos_q <= quad_cos(turn[31:30], ONE, '0);
							sin_q <= quad_sin(turn[31:30], ONE, '0);
						end else begin
							state_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					cos_q   <= quad_cos(quad_q, c_rnd, s_rnd);
					sin_q   <= quad_sin(quad_q, c_rnd, s_rnd);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/aptf_front.sv =====
module aptf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  aptf_pkg::point_t point,
	input  aptf_pkg::cfg_t   cfg,
	input  logic             trig_busy,
	input  logic             q_full,
	output logic             q_push,
	output aptf_pkg::delta_t q_data
);
	import aptf_pkg::*;

	logic   valid_s1;
	delta_t delta_s1;
	logic   accept;

	// hold off points while the angle resolves or s1 stalls
	assign full   = trig_busy || (valid_s1 && q_full);
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = delta_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_s1.dx <= DELTA_W'(point.point_x) - DELTA_W'(cfg.pivot_x);
			delta_s1.dy <= DELTA_W'(point.point_y) - DELTA_W'(cfg.pivot_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

endmodule

// ===== rtl/core/aptf_back.sv =====
module aptf_back #(
	parameter int OUT_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aptf_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  aptf_pkg::delta_t  q_data,
	output logic              q_pop,
	input  logic              out_pop,
	output logic              out_push,
	output aptf_pkg::result_t out_data
);
	import aptf_pkg::*;

	localparam int CR_W = $clog2(OUT_DEPTH) + 1;
	localparam int P_W  = TRIG_W + DELTA_W;
	localparam int S_W  = P_W + 1;
	localparam int U_W  = 36;
	localparam int UH_W = U_W - FRAC_BITS;
	localparam int HI_W = COORD_W + UH_W;
	localparam int LO_W = COORD_W + FRAC_BITS + 1;
	localparam int T_W  = HI_W + FRAC_BITS + 2;
	localparam int Q_W  = T_W - FRAC_BITS;
	localparam int R_W  = Q_W + 1;

	localparam logic signed [S_W-1:0] HALF_S = S_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [T_W-1:0] HALF_T = T_W'(1) <<< (FRAC_BITS - 1);

	logic [CR_W-1:0] credit_q;
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [P_W-1:0]  cdx_s1, sdy_s1, sdx_s1, cdy_s1;
	logic signed [U_W-1:0]  rx_s2, ry_s2;
	logic signed [U_W-1:0]  ux_s3, uy_s3;
	logic signed [HI_W-1:0] hix_s4, hiy_s4;
	logic signed [LO_W-1:0] lox_s4, loy_s4;
	logic signed [Q_W-1:0]  qx_s5, qy_s5;

	logic signed [S_W-1:0] sum_x, sum_y;
	logic signed [T_W-1:0] tot_x, tot_y;
	logic signed [R_W-1:0] rx_fin, ry_fin;
	logic                  sat_x, sat_y;

	// a slot in the result queue is reserved before an item enters the pipe
	assign q_pop = !q_empty && (credit_q != '0);

	assign sum_x = S_W'(cdx_s1) - S_W'(sdy_s1) + HALF_S;
	assign sum_y = S_W'(sdx_s1) + S_W'(cdy_s1) + HALF_S;

	assign tot_x = (T_W'(hix_s4) <<< FRAC_BITS) + T_W'(lox_s4) + HALF_T;
	assign tot_y = (T_W'(hiy_s4) <<< FRAC_BITS) + T_W'(loy_s4) + HALF_T;

	assign rx_fin = R_W'(qx_s5) + R_W'(cfg.position_x);
	assign ry_fin = R_W'(qy_s5) + R_W'(cfg.position_y);

	// out of range unless the bits above the sign all match it
	assign sat_x = !((&rx_fin[R_W-1:COORD_W-1]) || !(|rx_fin[R_W-1:COORD_W-1]));
	assign sat_y = !((&ry_fin[R_W-1:COORD_W-1]) || !(|ry_fin[R_W-1:COORD_W-1]));

	always_comb begin
		if (sat_x) begin
			out_data.result_x = rx_fin[R_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
				: {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			out_data.result_x = COORD_W'(rx_fin);
		end
		if (sat_y) begin
			out_data.result_y = ry_fin[R_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
				: {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			out_data.result_y = COORD_W'(ry_fin);
		end
		out_data.saturated = sat_x || sat_y;
	end

	assign out_push = v_s5;

	always_ff @(posedge clk) begin
		cdx_s1 <= cfg.cosine * q_data.dx;
		sdy_s1 <= cfg.sine * q_data.dy;
		sdx_s1 <= cfg.sine * q_data.dx;
		cdy_s1 <= cfg.cosine * q_data.dy;

		rx_s2 <= U_W'(sum_x >>> FRAC_BITS);
		ry_s2 <= U_W'(sum_y >>> FRAC_BITS);

		ux_s3 <= U_W'(cfg.offset_x) + U_W'(cfg.pivot_x) + rx_s2;
		uy_s3 <= U_W'(cfg.offset_y) + U_W'(cfg.pivot_y) + ry_s2;

		hix_s4 <= cfg.scale_factor * $signed(ux_s3[U_W-1:FRAC_BITS]);
		lox_s4 <= cfg.scale_factor * $signed({1'b0, ux_s3[FRAC_BITS-1:0]});
		hiy_s4 <= cfg.scale_factor * $signed(uy_s3[U_W-1:FRAC_BITS]);
		loy_s4 <= cfg.scale_factor * $signed({1'b0, uy_s3[FRAC_BITS-1:0]});

		qx_s5 <= Q_W'(tot_x >>> FRAC_BITS);
		qy_s5 <= Q_W'(tot_y >>> FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CR_W'(OUT_DEPTH);
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
		end else begin
			credit_q <= credit_q - CR_W'(q_pop) + CR_W'(out_pop);
			v_s1     <= q_pop;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
		end
	end

endmodule

// ===== rtl/core/affine_point_transform_2d_unit.sv =====
// path: front delta register, middle queue, five-stage multiply pipe, result queue
// throughput: one point per cycle while no cordic runs and the queues have room
// writing rotation_angle with a nonzero residual runs a 30-step cordic: input stays full
// and the config port not ready until it finishes; quarter-turn angles take effect at once
// reset: asynchronous, active low; queues empty, scale 1.0, angle 0, other registers 0
module affine_point_transform_2d_unit #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  aptf_pkg::point_t                    point,
	output logic                                empty,
	input  logic                                pop,
	output aptf_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aptf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [aptf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import aptf_pkg::*;

	cfg_t    cfg;
	logic    cfg_wr;
	logic    trig_start;
	logic    trig_busy;
	logic    mid_full, mid_empty, mid_push, mid_pop;
	delta_t  mid_wr_data, mid_rd_data;
	logic    out_push;
	result_t out_wr_data;
	logic    out_pop;

	logic signed [COORD_W-1:0] position_x_q, position_y_q, scale_factor_q;
	logic signed [COORD_W-1:0] offset_x_q, offset_y_q, pivot_x_q, pivot_y_q;
	logic signed [TRIG_W-1:0]  cosine, sine;

	assign cfg_ready  = !trig_busy;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign trig_start = cfg_wr && (cfg_index == REG_ROTATION_ANGLE);
	assign out_pop    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_x_q   <= '0;
			position_y_q   <= '0;
			scale_factor_q <= COORD_W'(1) <<< FRAC_BITS;
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			pivot_x_q      <= '0;
			pivot_y_q      <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_POSITION_X:   position_x_q   <= $signed(cfg_data);
				REG_POSITION_Y:   position_y_q   <= $signed(cfg_data);
				REG_SCALE_FACTOR: scale_factor_q <= $signed(cfg_data);
				REG_OFFSET_X:     offset_x_q     <= $signed(cfg_data);
				REG_OFFSET_Y:     offset_y_q     <= $signed(cfg_data);
				REG_PIVOT_X:      pivot_x_q      <= $signed(cfg_data);
				REG_PIVOT_Y:      pivot_y_q      <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.position_x   = position_x_q;
		cfg.position_y   = position_y_q;
		cfg.scale_factor = scale_factor_q;
		cfg.offset_x     = offset_x_q;
		cfg.offset_y     = offset_y_q;
		cfg.pivot_x      = pivot_x_q;
		cfg.pivot_y      = pivot_y_q;
		cfg.cosine       = cosine;
		cfg.sine         = sine;
	end

	aptf_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.angle  (cfg_data[ANGLE_W-1:0]),
		.busy   (trig_busy),
		.cosine (cosine),
		.sine   (sine)
	);

	aptf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.point     (point),
		.cfg       (cfg),
		.trig_busy (trig_busy),
		.q_full    (mid_full),
		.q_push    (mid_push),
		.q_data    (mid_wr_data)
	);

	aptf_fifo #(
		.WIDTH ($bits(delta_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr_data),
		.rd_en   (mid_pop),
		.rd_data (mid_rd_data),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	aptf_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (mid_empty),
		.q_data   (mid_rd_data),
		.q_pop    (mid_pop),
		.out_pop  (out_pop),
		.out_push (out_push),
		.out_data (out_wr_data)
	);

	// never overflows: the back end holds a credit for every slot
	aptf_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wr_data),
		.rd_en   (out_pop),
		.rd_data (result),
		.full    (),
		.empty   (empty)
	);

endmodule

// ===== rtl/core/aptf_checker.sv =====
module aptf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             full,
	input logic                             empty,
	input logic                             pop,
	input aptf_pkg::result_t                result,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [aptf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [aptf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import aptf_pkg::*;

	// an angle off a quarter turn starts the cordic and blocks both sides
	a_angle_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_ROTATION_ANGLE)
			&& (cfg_data[ANGLE_BITS-3:0] != '0)
		|=> !cfg_ready && full)
		else $error("angle write did not start trig derivation");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> full)
		else $error("points accepted while trig derivation runs");

	a_busy_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready && !cfg_valid |=> $stable(cfg_ready) || $rose(cfg_ready))
		else $error("config ready glitch during trig derivation");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

endmodule

bind affine_point_transform_2d_unit aptf_checker u_aptf_checker (.*);

// ===== tb/sv/tb_affine_point_transform_2d_unit.sv =====
`timescale 1ns / 1ps

module tb_affine_point_transform_2d_unit;
	import aptf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int POINTS_PER_SETTING = 50;
	localparam int RANDOM_SETTINGS = 8;
	localparam longint UNIT_GAIN = 652032874;
	localparam longint TURN_ATAN [0:29] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
		5, 3, 1
	};
	localparam logic [COORD_W-1:0] COORD_TOP = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] COORD_BOTTOM = 32'h8000_0000;

	class transform_scoreboard;
		logic signed [COORD_W-1:0] pos_x, pos_y, scale, off_x, off_y, piv_x, piv_y;
		logic [ANGLE_W-1:0] angle;
		logic signed [TRIG_W-1:0] cos_q, sin_q;
		result_t pending_results[$];
		int errors;
		int points_seen;
		int saturations;

		function new();
			pos_x = '0;
			pos_y = '0;
			scale = 1 << FRAC_BITS;
			off_x = '0;
			off_y = '0;
			piv_x = '0;
			piv_y = '0;
			angle = '0;
			cos_q = TRIG_W'(1 << FRAC_BITS);
			sin_q = '0;
			errors = 0;
			points_seen = 0;
			saturations = 0;
		endfunction

		function longint round_unit(longint v);
			longint r;
			r = (v + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			if (r > (longint'(1) << FRAC_BITS))
				r = longint'(1) << FRAC_BITS;
			if (r < -(longint'(1) << FRAC_BITS))
				r = -(longint'(1) << FRAC_BITS);
			return r;
		endfunction

		// quadrant from the top two bits, cordic on the residual
		function void derive_trig();
			logic [31:0] turn;
			longint x, y, z, xs, ys, c, s;
			turn = 32'(angle) << (32 - ANGLE_BITS);
			z = longint'(turn[29:0]);
			if (z == 0) begin
				c = longint'(1) << FRAC_BITS;
				s = 0;
			end else begin
				x = UNIT_GAIN;
				y = 0;
				for (int i = 0; i < 30; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (z >= 0) begin
						x -= ys;
						y += xs;
						z -= TURN_ATAN[i];
					end else begin
						x += ys;
						y -= xs;
						z += TURN_ATAN[i];
					end
				end
				c = round_unit(x);
				s = round_unit(y);
			end
			case (turn[31:30])
				2'd0: begin
					cos_q = TRIG_W'(c);
					sin_q = TRIG_W'(s);
				end
				2'd1: begin
					cos_q = TRIG_W'(-s);
					sin_q = TRIG_W'(c);
				end
				2'd2: begin
					cos_q = TRIG_W'(-c);
					sin_q = TRIG_W'(-s);
				end
				default: begin
					cos_q = TRIG_W'(s);
					sin_q = TRIG_W'(-c);
				end
			endcase
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_POSITION_X:   pos_x = data;
				REG_POSITION_Y:   pos_y = data;
				REG_SCALE_FACTOR: scale = data;
				REG_OFFSET_X:     off_x = data;
				REG_OFFSET_Y:     off_y = data;
				REG_PIVOT_X:      piv_x = data;
				REG_PIVOT_Y:      piv_y = data;
				REG_ROTATION_ANGLE: begin
					angle = data[ANGLE_W-1:0];
					derive_trig();
				end
				default: ;
			endcase
		endfunction

		// scale in two halves so the product stays exact in 64 bits
		function logic signed [COORD_W-1:0] scale_and_place(longint u, longint pos,
				inout bit sat);
			longint uh, ul, hi, sc, r;
			sc = longint'(scale);
			uh = u >>> 16;
			ul = u - uh * 65536;
			hi = sc * uh;
			if (hi >= (longint'(1) << 46)) begin
				sat = 1'b1;
				return COORD_TOP;
			end
			if (hi <= -(longint'(1) << 46)) begin
				sat = 1'b1;
				return COORD_BOTTOM;
			end
			r = ((hi * 65536 + sc * ul + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS) + pos;
			if (r > longint'(2147483647)) begin
				sat = 1'b1;
				return COORD_TOP;
			end
			if (r < -(longint'(1) << 31)) begin
				sat = 1'b1;
				return COORD_BOTTOM;
			end
			return r[COORD_W-1:0];
		endfunction

		function void note_point(point_t p);
			longint dx, dy, rx, ry, c, s, half;
			bit sat;
			result_t r;
			half = longint'(1) << (FRAC_BITS - 1);
			c = longint'(cos_q);
			s = longint'(sin_q);
			dx = longint'($signed(p.point_x)) - longint'(piv_x);
			dy = longint'($signed(p.point_y)) - longint'(piv_y);
			rx = (c * dx - s * dy + half) >>> FRAC_BITS;
			ry = (s * dx + c * dy + half) >>> FRAC_BITS;
			sat = 1'b0;
			r.result_x = scale_and_place(longint'(off_x) + longint'(piv_x) + rx,
				longint'(pos_x), sat);
			r.result_y = scale_and_place(longint'(off_y) + longint'(piv_y) + ry,
				longint'(pos_y), sat);
			r.saturated = sat;
			pending_results.push_back(r);
			points_seen++;
			if (sat)
				saturations++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result x=%0d y=%0d saturated=%0d",
					got.result_x, got.result_y, got.saturated);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.result_x !== want.result_x) begin
				$error("result_x: expected %0d, actual %0d", want.result_x, got.result_x);
				errors++;
			end
			if (got.result_y !== want.result_y) begin
				$error("result_y: expected %0d, actual %0d", want.result_y, got.result_y);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	point_t point;
	logic empty;
	logic pop;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	transform_scoreboard board;
	bit steady;
	int stall_cycles;
	int settings_run;

	affine_point_transform_2d_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.point(point),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit take_break();
		return !steady && $urandom_range(0, 99) < 7;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return COORD_TOP;
					1: return COORD_BOTTOM;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return 1 << FRAC_BITS;
			1: return $urandom;
			2: return $urandom_range(0, 1) ? COORD_TOP : COORD_BOTTOM;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	// monitors, result side pop and the progress watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_point(point);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (pop && !empty)
				board.check_result(result);
		end
		if ((push && !full) || (cfg_valid && cfg_ready) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$error("no request or result moved for %0d cycles", STALL_LIMIT);
			$display("tb_affine_point_transform_2d_unit failed");
			$finish;
		end
		pop <= arst_n && !take_break();
	end

	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		point_t p;
		p.point_x = x;
		p.point_y = y;
		if (take_break()) begin
			push <= 1'b0;
			@(posedge clk);
		end
		point <= p;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	// hold requests back until every expected result is out
	task automatic drain();
		push <= 1'b0;
		while (board.pending_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_transform(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
			input logic [COORD_W-1:0] sc, input logic [COORD_W-1:0] ox,
			input logic [COORD_W-1:0] oy, input logic [COORD_W-1:0] vx,
			input logic [COORD_W-1:0] vy, input logic [ANGLE_W-1:0] ang);
		write_register(REG_POSITION_X, px);
		write_register(REG_POSITION_Y, py);
		write_register(REG_SCALE_FACTOR, sc);
		write_register(REG_OFFSET_X, ox);
		write_register(REG_OFFSET_Y, oy);
		write_register(REG_PIVOT_X, vx);
		write_register(REG_PIVOT_Y, vy);
		write_register(REG_ROTATION_ANGLE, {16'h0, ang});
		settings_run++;
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		point = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		stall_cycles = 0;
		settings_run = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity transform out of reset
		send_point('0, '0);
		send_point(COORD_TOP, COORD_TOP);
		send_point(COORD_BOTTOM, COORD_BOTTOM);
		send_point(COORD_TOP, COORD_BOTTOM);
		send_point('1, 32'h0000_0001);

		// exact quarter turn, rotating the most negative y overflows x
		set_transform('0, '0, 1 << FRAC_BITS, '0, '0, '0, '0, 16'd16384);
		send_point(COORD_BOTTOM, COORD_TOP);
		send_point(COORD_TOP, COORD_BOTTOM);

		// eighth turn about an off-center pivot at half scale, exercises rounding
		set_transform(32'h0003_8000, 32'hfffe_c000, 32'h0000_8000, 32'h0000_4000,
			32'hffff_0001, 32'h0001_8000, 32'hfffd_c000, 16'd8192);
		send_point('0, '0);
		send_point(32'h0000_0001, 32'h0000_0001);
		send_point(32'h0001_8000, 32'hfffd_c000);
		send_point('1, '1);
		send_point(COORD_BOTTOM, COORD_TOP);

		// most negative scale: large terms clamp before the final sum
		set_transform(COORD_TOP, '0, COORD_BOTTOM, COORD_BOTTOM, '0, COORD_TOP, '0, 16'hffff);
		send_point(COORD_TOP, COORD_TOP);
		send_point(COORD_TOP, '0);
		send_point('0, '0);

		// largest scale, three-quarter turn, final sum saturates low
		set_transform(COORD_BOTTOM, COORD_TOP, COORD_TOP, '0, '0, '0, COORD_BOTTOM,
			16'd49152);
		send_point('0, 32'h0001_0000);
		send_point(COORD_BOTTOM, '0);
		send_point(32'h0000_0002, 32'hffff_fffe);

		// zero scale leaves only the position; unknown indexes change nothing
		set_transform(COORD_TOP, COORD_BOTTOM, '0, '1, '1, '1, '1, 16'd32768);
		write_register(4'd8, '1);
		write_register(4'd15, 32'h0000_1234);
		send_point(COORD_TOP, COORD_BOTTOM);
		send_point(32'h1234_5678, 32'h8765_4321);

		for (int k = 0; k < RANDOM_SETTINGS; k++) begin
			set_transform(pick_coord(), pick_coord(), pick_scale(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord(),
				$urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3) << 14)
					: 16'($urandom_range(0, 65535)));
			if ($urandom_range(0, 3) == 0)
				write_register(4'($urandom_range(8, 15)), $urandom);
			steady = (k == 2);
			for (int n = 0; n < POINTS_PER_SETTING; n++) begin
				if (k == 4 && n == POINTS_PER_SETTING / 2)
					drain();
				send_point(pick_coord(), pick_coord());
			end
		end
		steady = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d points checked over %0d transform settings, %0d of them saturated",
			board.points_seen, settings_run, board.saturations);
		if (board.errors == 0)
			$display("tb_affine_point_transform_2d_unit passed");
		else
			$display("tb_affine_point_transform_2d_unit failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/aptf_pkg.sv
rtl/core/aptf_fifo.sv
rtl/core/aptf_trig.sv
rtl/core/aptf_front.sv
rtl/core/aptf_back.sv
rtl/core/affine_point_transform_2d_unit.sv
rtl/core/aptf_checker.sv
tb/sv/tb_affine_point_transform_2d_unit.sv
